// ----- src/utf8_stream_validator_assert.svh -----
// assertion macros for the utf8 stream validator checker
// expects signals clk and rst in the scope of use
`ifndef UTF8_STREAM_VALIDATOR_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_ASSERT_SVH

// clocked property, ignored while reset is high
`define U8V_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked during reset
`define U8V_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/utf8v_pkg.sv -----
// shared types, constants and helpers of the utf8 stream validator
// no dependencies
`default_nettype none

package utf8v_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int OUT_BITS    = 32;

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [OUT_BITS-1:0]    word_t;

  typedef enum logic [2:0] {
    ST_MID      = 3'd0,
    ST_DONE     = 3'd1,
    ST_BAD_LEAD = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_BAD_CONT = 3'd4,
    ST_OVERLONG = 3'd5,
    ST_HALTED   = 3'd6
  } status_t;

  localparam logic [7:0] MASK_ASCII = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] PAT_LEAD4  = 8'hF0;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;
  localparam logic [7:0] MASK_OVL2  = 8'h1E;
  localparam logic [7:0] MASK_OVL3  = 8'h20;
  localparam logic [7:0] MASK_OVL4  = 8'h30;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_F0    = 8'hF0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_last;
  } item_t;

  typedef struct packed {
    status_t    status;
    word_t      char_offset;
    logic [2:0] char_length;
    word_t      char_total;
    word_t      error_offset;
    logic       stream_end;
  } result_t;

  // sequence length from the lead byte, 0 for an invalid lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    if ((b & MASK_ASCII) == 8'h00)            n = 3'd1;
    else if ((b & MASK_LEAD2) == PAT_LEAD2)   n = 3'd2;
    else if ((b & MASK_LEAD3) == PAT_LEAD3)   n = 3'd3;
    else if ((b & MASK_LEAD4) == PAT_LEAD4)   n = 3'd4;
    else                                      n = 3'd0;
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- src/utf8v_if.sv -----
// byte and character channel interfaces of the utf8 stream validator
// depends on utf8v_pkg
`default_nettype none

interface utf8v_byte_if
  import utf8v_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_last;

  modport source (output valid, output data_byte, output stream_last, input ready);
  modport sink   (input valid, input data_byte, input stream_last, output ready);
endinterface

interface utf8v_char_if
  import utf8v_pkg::*;
;
  logic       valid;
  logic       ready;
  status_t    status;
  word_t      char_offset;
  logic [2:0] char_length;
  word_t      char_total;
  word_t      error_offset;
  logic       stream_end;

  modport source (output valid, output status, output char_offset, output char_length,
                  output char_total, output error_offset, output stream_end, input ready);
  modport sink   (input valid, input status, input char_offset, input char_length,
                  input char_total, input error_offset, input stream_end, output ready);
endinterface

`default_nettype wire

// ----- src/utf8v_in_stage.sv -----
// input register of the utf8 stream validator
// depends on utf8v_pkg
`default_nettype none

module utf8v_in_stage
  import utf8v_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  q_valid,
  output item_t q_item
);

  logic take;

  assign in_ready = !q_valid || advance;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (take) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- src/utf8v_core.sv -----
// per-byte decode state and step logic of the utf8 stream validator
// depends on utf8v_pkg
`default_nettype none

module utf8v_core
  import utf8v_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  output result_t res
);

  logic [1:0]  bytes_left,  bytes_left_next;
  logic [2:0]  seq_len,     seq_len_next;
  logic [7:0]  lead_byte,   lead_byte_next;
  off_t        lead_offset, lead_offset_next;
  off_t        byte_offset, byte_offset_next;
  logic [31:0] char_counter, char_counter_next;
  logic        cont_error_pending, cont_error_pending_next;
  off_t        cont_error_offset,  cont_error_offset_next;
  logic        halted,      halted_next;
  logic        overlong_pending, overlong_pending_next;

  logic [7:0]  b;
  logic [2:0]  n;
  logic        err, active, complete;
  status_t     status;
  off_t        coff, eoff;
  logic [2:0]  clen;

  assign b = item.data_byte;
  assign n = lead_length(b);

  always_comb begin
    bytes_left_next         = bytes_left;
    seq_len_next            = seq_len;
    lead_byte_next          = lead_byte;
    lead_offset_next        = lead_offset;
    char_counter_next       = char_counter;
    cont_error_pending_next = cont_error_pending;
    cont_error_offset_next  = cont_error_offset;
    overlong_pending_next   = overlong_pending;
    status   = ST_MID;
    coff     = '0;
    eoff     = '0;
    clen     = 3'd0;
    err      = 1'b0;
    active   = 1'b0;
    complete = 1'b0;

    if (halted) begin
      status = ST_HALTED;
    end else if (bytes_left == 2'd0) begin
      if (n == 3'd0) begin
        status = ST_BAD_LEAD;
        coff   = byte_offset;
        eoff   = byte_offset;
        err    = 1'b1;
      end else begin
        lead_offset_next        = byte_offset;
        lead_byte_next          = b;
        seq_len_next            = n;
        bytes_left_next         = 2'(n - 3'd1);
        cont_error_pending_next = 1'b0;
        cont_error_offset_next  = '0;
        overlong_pending_next   = (n == 3'd2) && ((b & MASK_OVL2) == 8'h00);
        active                  = 1'b1;
        complete                = (n == 3'd1);
      end
    end else begin
      if (((b & MASK_CONT) != PAT_CONT) && !cont_error_pending) begin
        cont_error_pending_next = 1'b1;
        cont_error_offset_next  = byte_offset;
      end
      // second byte of the character decides the E0 and F0 overlong forms
      if (seq_len == 3'({1'b0, bytes_left}) + 3'd1) begin
        if ((seq_len == 3'd3 && lead_byte == LEAD_E0 && (b & MASK_OVL3) == 8'h00) ||
            (seq_len == 3'd4 && lead_byte == LEAD_F0 && (b & MASK_OVL4) == 8'h00)) begin
          overlong_pending_next = 1'b1;
        end
      end
      bytes_left_next = bytes_left - 2'd1;
      active          = 1'b1;
      complete        = (bytes_left == 2'd1);
    end

    if (active) begin
      coff = lead_offset_next;
      if (complete) begin
        if (cont_error_pending_next) begin
          status = ST_BAD_CONT;
          eoff   = cont_error_offset_next;
          err    = 1'b1;
        end else if (overlong_pending_next) begin
          status = ST_OVERLONG;
          eoff   = lead_offset_next;
          err    = 1'b1;
        end else begin
          status = ST_DONE;
          clen   = seq_len_next;
          if (char_counter != '1) begin
            char_counter_next = char_counter + 32'd1;
          end
        end
      end else if (item.stream_last) begin
        status = ST_TRUNC;
        eoff   = lead_offset_next;
        err    = 1'b1;
      end
    end

    byte_offset_next = (byte_offset != '1) ? byte_offset + off_t'(1) : byte_offset;
    halted_next      = halted || err;
  end

  always_comb begin
    res.status       = status;
    res.char_offset  = OUT_BITS'(coff);
    res.char_length  = clen;
    res.char_total   = char_counter_next;
    res.error_offset = OUT_BITS'(eoff);
    res.stream_end   = item.stream_last;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.stream_last)) begin
      bytes_left         <= 2'd0;
      seq_len            <= 3'd0;
      lead_byte          <= 8'd0;
      lead_offset        <= '0;
      byte_offset        <= '0;
      char_counter       <= '0;
      cont_error_pending <= 1'b0;
      cont_error_offset  <= '0;
      halted             <= 1'b0;
      overlong_pending   <= 1'b0;
    end else if (step) begin
      bytes_left         <= bytes_left_next;
      seq_len            <= seq_len_next;
      lead_byte          <= lead_byte_next;
      lead_offset        <= lead_offset_next;
      byte_offset        <= byte_offset_next;
      char_counter       <= char_counter_next;
      cont_error_pending <= cont_error_pending_next;
      cont_error_offset  <= cont_error_offset_next;
      halted             <= halted_next;
      overlong_pending   <= overlong_pending_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/utf8v_out_stage.sv -----
// result register of the utf8 stream validator
// depends on utf8v_pkg
`default_nettype none

module utf8v_out_stage
  import utf8v_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

// ----- src/utf8_stream_validator.sv -----
// Streaming UTF-8 splitter and checker. One byte enters per transaction on
// the bytes channel, with stream_last on the final byte of a stream, and
// every byte yields exactly one transaction on the chars channel. The block
// sustains one byte per clock cycle while the chars side takes results: a
// byte is latched in the input register, decoded against the character
// state, and its result lands in the result register, from which it is
// offered. The result register parts the two sides; while a result
// waits, a new byte is still accepted if the input register is empty or
// the result register will free up in the same cycle. Status reports mid
// character, character done (with its start offset and length), bad lead,
// truncation at stream end, bad continuation (reported on the character's
// last byte, pointing at the first bad byte) or overlong form (C0/C1, E0
// and F0 leads only). The first error halts the stream: later bytes report
// halted until the byte carrying stream_last, after which all state clears
// and a new stream begins. Byte offsets and the character count saturate.
// Surrogates and code points above U+10FFFF are not flagged.
// depends on utf8v_pkg, utf8v_if, utf8v_in_stage, utf8v_core, utf8v_out_stage
`default_nettype none

module utf8_stream_validator
  import utf8v_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  utf8v_byte_if.sink          bytes,
  utf8v_char_if.source        chars
);

  // input side
  item_t   in_item;
  logic    q_valid;
  item_t   q_item;

  // decode and result side
  result_t res;
  result_t out_res;
  logic    can_load;
  logic    advance;

  assign in_item.data_byte   = bytes.data_byte;
  assign in_item.stream_last = bytes.stream_last;

  // a latched byte moves on when the result register has room
  assign advance = q_valid && can_load;

  utf8v_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bytes.valid),
    .in_ready (bytes.ready),
    .in_item  (in_item),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  // state only changes when the byte's result is written
  utf8v_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (q_item),
    .res  (res)
  );

  utf8v_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res       (res),
    .can_load  (can_load),
    .out_valid (chars.valid),
    .out_ready (chars.ready),
    .out_res   (out_res)
  );

  // result fields onto the chars channel
  assign chars.status       = out_res.status;
  assign chars.char_offset  = out_res.char_offset;
  assign chars.char_length  = out_res.char_length;
  assign chars.char_total   = out_res.char_total;
  assign chars.error_offset = out_res.error_offset;
  assign chars.stream_end   = out_res.stream_end;

endmodule

`default_nettype wire

// ----- src/utf8v_checker.sv -----
// port-level assertions for the utf8 stream validator, with its bind
// depends on utf8v_pkg and utf8_stream_validator_assert.svh
`default_nettype none
`include "utf8_stream_validator_assert.svh"

module utf8v_checker
  import utf8v_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input status_t    status,
  input word_t      char_offset,
  input logic [2:0] char_length,
  input word_t      error_offset
);

  // a stalled result stays offered, with its status and length unchanged
  `U8V_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(char_length), "result dropped or changed while stalled")

  // only a finished character carries a length, and it is 1 to 4
  `U8V_ASSERT(a_len_done, out_valid && status == ST_DONE |-> char_length != 3'd0 && char_length <= 3'd4, "finished character with bad length")

  `U8V_ASSERT(a_len_other, out_valid && status != ST_DONE |-> char_length == 3'd0, "length reported without a finished character")

  // halted results carry no offsets
  `U8V_ASSERT(a_halted_zero, out_valid && status == ST_HALTED |-> char_offset == '0 && error_offset == '0, "halted result with nonzero offsets")

  // nothing is offered right after reset
  `U8V_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !out_valid, "result offered after reset")

endmodule

bind utf8_stream_validator utf8v_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (chars.valid),
  .out_ready    (chars.ready),
  .status       (chars.status),
  .char_offset  (chars.char_offset),
  .char_length  (chars.char_length),
  .error_offset (chars.error_offset)
);

`default_nettype wire
